/* hw/rtl/ptb_pkg.sv */
// Shared constants, types and codes of the PRD table builder.
package ptb_pkg;

  // Table capacity and derived counter width
  localparam int TABLE_ENTRIES = 64;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  // Fixed field widths
  localparam int ADDR_W  = 32;
  localparam int CLEN_W  = 22;
  localparam int ELEN_W  = 16;
  localparam int IDX_W   = 6;
  localparam int PIECE_W = 17;

  localparam logic [PIECE_W-1:0] WINDOW    = 17'h10000;
  localparam logic [CLEN_W-1:0]  MAX_CHUNK = 22'd4063232;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ADDR_OVF   = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_EMPTY_JOB  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SPLIT,
    S_FINISH,
    S_FLUSH
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic step;
    logic finish;
    logic flush;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic failed_eff;
    logic len_zero;
    logic can_push;
    logic stg_valid;
    logic out_free;
  } sts_t;

  // One table entry word
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [ELEN_W-1:0] len;
    logic              eot;
    logic [IDX_W-1:0]  idx;
    status_e           status;
  } entry_t;

endpackage

/* hw/rtl/prd_table_builder.sv */
// Top level of the PRD table builder: controller plus datapath.
//
// Takes the memory chunks of one DMA job and returns ATA bus-master PRD
// entries, split at 64 KiB boundaries, the newest entry held back so that the
// job's final entry carries the end-of-table mark. One chunk is worked on at a
// time: after acceptance, the split loop steps once per 64 KiB piece, then
// checks for loop exit, handles the job end and flushes the staged word
// before the next ready, and the output side can stall each step; a chunk of
// a failed job is dropped at acceptance. The split loop steps one piece per
// cycle while the output side does not stall. The last result word of each
// chunk carries last_of_run.
module prd_table_builder import ptb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ADDR_W-1:0] chunk_address_i,
  input  logic [CLEN_W-1:0] chunk_length_i,
  input  logic              first_chunk_i,
  input  logic              last_chunk_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ADDR_W-1:0] entry_address_o,
  output logic [ELEN_W-1:0] entry_length_o,
  output logic              end_of_table_o,
  output logic [IDX_W-1:0]  entry_index_o,
  output logic [1:0]        status_o,
  output logic              last_of_run_o
);

  cmd_t   cmd;
  sts_t   sts;
  entry_t out_entry;

  ptb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ptb_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .chunk_address_i (chunk_address_i),
    .chunk_length_i  (chunk_length_i),
    .first_chunk_i   (first_chunk_i),
    .last_chunk_i    (last_chunk_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .out_entry_o     (out_entry),
    .out_last_o      (last_of_run_o)
  );

  assign entry_address_o = out_entry.addr;
  assign entry_length_o  = out_entry.len;
  assign end_of_table_o  = out_entry.eot;
  assign entry_index_o   = out_entry.idx;
  assign status_o        = out_entry.status;

endmodule

/* hw/rtl/ptb_ctrl.sv */
// Sequencer of the PRD table builder: accept, split loop, job end, flush.
module ptb_ctrl import ptb_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  sts_t   sts_i,
  output cmd_t   cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && !sts_i.failed_eff) state_d = S_SPLIT;
      end
      S_SPLIT: begin
        if (sts_i.len_zero) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (sts_i.can_push) state_d = S_FLUSH;
      end
      S_FLUSH: begin
        if (!sts_i.stg_valid || sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      S_SPLIT: begin
        cmd_o.step = !sts_i.len_zero && sts_i.can_push;
      end
      S_FINISH: begin
        cmd_o.finish = sts_i.can_push;
      end
      S_FLUSH: begin
        cmd_o.flush = sts_i.stg_valid && sts_i.out_free;
      end
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

/* hw/rtl/ptb_datapath.sv */
// Datapath of the PRD table builder: chunk split, pending entry, staging, output word.
module ptb_datapath import ptb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [ADDR_W-1:0] chunk_address_i,
  input  logic [CLEN_W-1:0] chunk_length_i,
  input  logic              first_chunk_i,
  input  logic              last_chunk_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output entry_t            out_entry_o,
  output logic              out_last_o
);

  // Working chunk
  logic [ADDR_W:0]     addr_q, addr_d;
  logic [CLEN_W-1:0]   len_q, len_d;
  logic                last_q, last_d;
  // Job state
  logic [ADDR_W-1:0]   pend_addr_q, pend_addr_d;
  logic [ELEN_W-1:0]   pend_len_q, pend_len_d;
  logic                pend_valid_q, pend_valid_d;
  logic [CNT_W-1:0]    entries_q, entries_d;
  logic                failed_q, failed_d;
  // Staged result and output register
  entry_t              stg_q, stg_d;
  logic                stg_valid_q, stg_valid_d;
  entry_t              out_q, out_d;
  logic                out_last_q, out_last_d;
  logic                out_valid_q, out_valid_d;

  logic                push;
  entry_t              push_entry;
  logic [PIECE_W-1:0]  piece_room, piece;
  logic [CNT_W-1:0]    last_idx;
  logic                failed_eff, out_free;

  // Piece size: bytes left in this 64 KiB window, cut to the chunk remainder
  assign piece_room = WINDOW - {1'b0, addr_q[15:0]};
  assign piece      = ({5'b0, piece_room} > len_q) ? len_q[PIECE_W-1:0] : piece_room;
  assign last_idx   = entries_q - CNT_W'(1);
  assign failed_eff = failed_q && !first_chunk_i;
  assign out_free   = !out_valid_q || out_ready_i;

  assign sts_o.failed_eff = failed_eff;
  assign sts_o.len_zero   = (len_q == '0);
  assign sts_o.can_push   = !stg_valid_q || out_free;
  assign sts_o.stg_valid  = stg_valid_q;
  assign sts_o.out_free   = out_free;

  // Job state update
  always_comb begin
    addr_d       = addr_q;
    len_d        = len_q;
    last_d       = last_q;
    pend_addr_d  = pend_addr_q;
    pend_len_d   = pend_len_q;
    pend_valid_d = pend_valid_q;
    entries_d    = entries_q;
    failed_d     = failed_q;
    push         = 1'b0;
    push_entry   = '0;

    if (cmd_i.accept) begin
      addr_d = {1'b0, chunk_address_i};
      len_d  = chunk_length_i;
      last_d = last_chunk_i;
      if (first_chunk_i) begin
        pend_addr_d  = '0;
        pend_len_d   = '0;
        pend_valid_d = 1'b0;
        entries_d    = '0;
        failed_d     = 1'b0;
      end
      if (failed_eff) begin
        len_d = '0;
        // failed job closes silently on its last chunk
        if (last_chunk_i) begin
          pend_addr_d  = '0;
          pend_len_d   = '0;
          pend_valid_d = 1'b0;
          entries_d    = '0;
          failed_d     = 1'b0;
        end
      end else if (chunk_length_i > MAX_CHUNK) begin
        push              = 1'b1;
        push_entry.status = ST_TABLE_FULL;
        pend_addr_d       = '0;
        pend_len_d        = '0;
        pend_valid_d      = 1'b0;
        failed_d          = 1'b1;
        len_d             = '0;
      end
    end

    if (cmd_i.step) begin
      if (addr_q[ADDR_W] || (entries_q >= CNT_W'(TABLE_ENTRIES))) begin
        push              = 1'b1;
        push_entry.status = addr_q[ADDR_W] ? ST_ADDR_OVF : ST_TABLE_FULL;
        pend_addr_d       = '0;
        pend_len_d        = '0;
        pend_valid_d      = 1'b0;
        failed_d          = 1'b1;
        len_d             = '0;
      end else begin
        // older pending entry goes out, the new piece becomes pending
        if (pend_valid_q) begin
          push            = 1'b1;
          push_entry.addr = pend_addr_q;
          push_entry.len  = pend_len_q;
          push_entry.idx  = IDX_W'(last_idx);
        end
        pend_addr_d  = addr_q[ADDR_W-1:0];
        pend_len_d   = piece[ELEN_W-1:0];
        pend_valid_d = 1'b1;
        entries_d    = entries_q + CNT_W'(1);
        addr_d       = addr_q + (ADDR_W+1)'(piece);
        len_d        = len_q - CLEN_W'(piece);
      end
    end

    if (cmd_i.finish && last_q) begin
      if (!failed_q) begin
        push = 1'b1;
        if (pend_valid_q) begin
          push_entry.addr = pend_addr_q;
          push_entry.len  = pend_len_q;
          push_entry.eot  = 1'b1;
          push_entry.idx  = IDX_W'(last_idx);
        end else begin
          push_entry.status = ST_EMPTY_JOB;
        end
      end
      pend_addr_d  = '0;
      pend_len_d   = '0;
      pend_valid_d = 1'b0;
      entries_d    = '0;
      failed_d     = 1'b0;
    end
  end

  // Staging and output word movement
  always_comb begin
    stg_d       = stg_q;
    stg_valid_d = stg_valid_q;
    out_d       = out_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (push) begin
      if (stg_valid_q) begin
        out_d       = stg_q;
        out_last_d  = 1'b0;
        out_valid_d = 1'b1;
      end
      stg_d       = push_entry;
      stg_valid_d = 1'b1;
    end
    if (cmd_i.flush) begin
      out_d       = stg_q;
      out_last_d  = 1'b1;
      out_valid_d = 1'b1;
      stg_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_addr_q  <= '0;
      pend_len_q   <= '0;
      pend_valid_q <= 1'b0;
      entries_q    <= '0;
      failed_q     <= 1'b0;
      stg_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_addr_q  <= pend_addr_d;
      pend_len_q   <= pend_len_d;
      pend_valid_q <= pend_valid_d;
      entries_q    <= entries_d;
      failed_q     <= failed_d;
      stg_valid_q  <= stg_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    len_q      <= len_d;
    last_q     <= last_d;
    stg_q      <= stg_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_entry_o = out_q;
  assign out_last_o  = out_last_q;

  // Checks
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entries_q <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count beyond table capacity");

  a_pend_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (entries_q != '0))
    else $error("pending entry without entry count");

  a_failed_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q |-> !pend_valid_q)
    else $error("failed job still holds a pending entry");

  a_flush_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush |=> (!stg_valid_q && out_valid_q && out_last_q))
    else $error("flush did not move the staged word out");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && stg_valid_q) |-> out_free)
    else $error("staged word pushed over a waiting output word");

endmodule
